/* hdl/sfdf_pkg.sv */
`timescale 1ns / 1ps

package sfdf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CFG_W     = 16;

    typedef logic [2:0]       t_reg_idx;
    typedef logic [CFG_W-1:0] t_gain;

    localparam t_reg_idx REG_DELAY_LEFT    = 3'd0;
    localparam t_reg_idx REG_DELAY_RIGHT   = 3'd1;
    localparam t_reg_idx REG_FEEDBACK_GAIN = 3'd2;
    localparam t_reg_idx REG_WET_GAIN      = 3'd3;
    localparam t_reg_idx REG_HIGHPASS_COEF = 3'd4;
    localparam t_reg_idx REG_LOWPASS_COEF  = 3'd5;
    localparam t_reg_idx REG_CROSS_MODE    = 3'd6;

    localparam logic [FRAC_BITS:0] GAIN_ONE = 17'd65536;
    localparam int                 RND_HALF = 32768;

    localparam int    RST_DELAY    = 13230;
    localparam t_gain RST_FEEDBACK = 16'd26214;
    localparam t_gain RST_WET      = 16'd32768;
    localparam t_gain RST_HIGHPASS = 16'd3277;
    localparam t_gain RST_LOWPASS  = 16'd62259;

endpackage

/* hdl/stereo_feedback_delay_filtered.sv */
// An accepted transfer steps through S_MUL1, S_MUL2, S_MUL3 and S_WR to its result in the output register.
// The filter and feedback sequencer takes one stereo item at a time, accepting the next only in S_IDLE.
// A write to either delay register starts a modulo reduction (multiply, then subtract); input waits for it.
// Reset (synchronous, active low) clears the pointer, filter states and output valid, and loads the
// register defaults; line entries not written since reset read as zero via fill tracking, no clearing pass.
`timescale 1ns / 1ps

module stereo_feedback_delay_filtered
    import sfdf_pkg::*;
#(
    parameter int DELAY_DEPTH = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  t_reg_idx                      i_cfg_addr,
    input  logic [CFG_W-1:0]              i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_left_in,
    input  logic signed [SAMPLE_BITS-1:0] i_right_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [SAMPLE_BITS-1:0] o_left_out,
    output logic signed [SAMPLE_BITS-1:0] o_right_out
);

    localparam int SB  = SAMPLE_BITS;
    localparam int ST  = SAMPLE_BITS + 8;
    localparam int DW  = ST + 2;
    localparam int PW  = DW + FRAC_BITS + 1;
    localparam int WD  = PW + 1;
    localparam int AW  = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int IW  = ((AW > CFG_W) ? AW : CFG_W) + 1;
    localparam int RCP_SH    = 32;
    localparam int RED_STEPS = 2;
    localparam int RCW       = $clog2(RED_STEPS + 1);

    localparam logic [CFG_W-1:0]  RST_DELAY_REM = CFG_W'(RST_DELAY % DELAY_DEPTH);
    localparam logic [IW-1:0]     DEPTH_IW      = IW'(DELAY_DEPTH);
    localparam logic [AW-1:0]     WP_LAST       = AW'(DELAY_DEPTH - 1);
    localparam logic [RCP_SH-1:0] RECIP         =
        RCP_SH'(((64'd1 << RCP_SH) + 64'(DELAY_DEPTH) - 64'd1) / 64'(DELAY_DEPTH));
    localparam logic [RCW-1:0]    RED_MUL       = RCW'(RED_STEPS);
    localparam logic [RCW-1:0]    RED_SUB       = RCW'(1);

    localparam logic signed [WD-1:0] ST_MAX = {{(WD-ST+1){1'b0}}, {(ST-1){1'b1}}};
    localparam logic signed [WD-1:0] ST_MIN = ~ST_MAX;
    localparam logic signed [WD-1:0] SB_MAX = {{(WD-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [WD-1:0] SB_MIN = ~SB_MAX;
    localparam logic signed [WD-1:0] HALF   = WD'(RND_HALF);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_MUL3 = 3'd3;
    localparam logic [2:0] S_WR   = 3'd4;

    function automatic logic signed [WD-1:0] rnd16(input logic signed [WD-1:0] p);
        logic signed [WD-1:0] s;
        s = p + HALF;
        return s >>> FRAC_BITS;
    endfunction

    function automatic logic signed [ST-1:0] sat_st(input logic signed [WD-1:0] v);
        logic signed [ST-1:0] res;
        if (v > ST_MAX) begin
            res = ST_MAX[ST-1:0];
        end else if (v < ST_MIN) begin
            res = ST_MIN[ST-1:0];
        end else begin
            res = v[ST-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [SB-1:0] sat_sb(input logic signed [WD-1:0] v);
        logic signed [SB-1:0] res;
        if (v > SB_MAX) begin
            res = SB_MAX[SB-1:0];
        end else if (v < SB_MIN) begin
            res = SB_MIN[SB-1:0];
        end else begin
            res = v[SB-1:0];
        end
        return res;
    endfunction

    logic [2:0]              r_state, n_state;
    logic [AW-1:0]           r_wp;
    logic                    r_wrapped;
    logic [CFG_W-1:0]        r_delay_rem [2];
    logic [CFG_W-1:0]        r_quot      [2];
    logic [RCW-1:0]          r_red_cnt;
    t_gain                   r_fb_gain, r_wet_gain, r_hp_coef, r_lp_coef;
    logic                    r_cross;

    logic signed [SB-1:0]    r_mem_left  [DELAY_DEPTH];
    logic signed [SB-1:0]    r_mem_right [DELAY_DEPTH];
    logic signed [SB-1:0]    r_rd   [2];
    logic                    r_tv   [2];
    logic signed [SB-1:0]    r_x    [2];
    logic signed [SB-1:0]    r_tap  [2];
    logic signed [DW-1:0]    r_y    [2];
    logic signed [ST-1:0]    r_hp   [2];
    logic signed [ST-1:0]    r_lp   [2];
    logic signed [PW-1:0]    r_p_hp [2];
    logic signed [PW-1:0]    r_p_lp [2];
    logic signed [PW-1:0]    r_p_dry[2];
    logic signed [PW-1:0]    r_p_wet[2];
    logic signed [PW-1:0]    r_p_fb [2];
    logic signed [SB-1:0]    r_mix  [2];
    logic                    r_out_valid;
    logic signed [SB-1:0]    r_out  [2];

    logic [AW-1:0]           rd_addr [2];
    logic [IW-1:0]           addr_diff [2];
    logic [CFG_W+RCP_SH-1:0] prod_c [2];
    logic [CFG_W+IW-1:0]     qd_c   [2];
    logic                    dly_we [2];
    logic signed [SB-1:0]    tap_w  [2];
    logic signed [DW-1:0]    y_c    [2];
    logic signed [DW-1:0]    d_c    [2];
    logic signed [DW-1:0]    zmy_c  [2];
    logic signed [PW-1:0]    p_hp_c [2];
    logic signed [PW-1:0]    p_lp_c [2];
    logic signed [PW-1:0]    p_dry_c[2];
    logic signed [PW-1:0]    p_wet_c[2];
    logic signed [PW-1:0]    p_fb_c [2];
    logic signed [WD-1:0]    fb_c   [2];
    logic signed [SB-1:0]    wr_c   [2];
    logic signed [SB-1:0]    in_c   [2];
    logic [FRAC_BITS:0]      dry_gain;
    logic                    accept;
    logic                    mem_we;

    assign o_in_ready  = (r_state == S_IDLE) && (r_red_cnt == '0);
    assign accept      = i_in_valid && o_in_ready;
    assign mem_we      = (r_state == S_WR) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_left_out  = r_out[0];
    assign o_right_out = r_out[1];
    assign in_c[0]     = i_left_in;
    assign in_c[1]     = i_right_in;
    assign dry_gain    = GAIN_ONE - {1'b0, r_wet_gain};

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            addr_diff[c] = IW'(r_wp) - IW'(r_delay_rem[c]);
            if (addr_diff[c][IW-1]) begin
                addr_diff[c] = addr_diff[c] + DEPTH_IW;
            end
            rd_addr[c] = addr_diff[c][AW-1:0];

            prod_c[c]  = (CFG_W+RCP_SH)'(r_delay_rem[c]) * (CFG_W+RCP_SH)'(RECIP);
            qd_c[c]    = (CFG_W+IW)'(r_quot[c]) * (CFG_W+IW)'(DEPTH_IW);

            tap_w[c]   = r_tv[c] ? r_rd[c] : '0;
            y_c[c]     = DW'(tap_w[c]) - DW'(r_hp[c]);
            d_c[c]     = y_c[c] - DW'(r_hp[c]);
            zmy_c[c]   = DW'(r_lp[c]) - y_c[c];
            p_hp_c[c]  = $signed({1'b0, r_hp_coef}) * d_c[c];
            p_lp_c[c]  = $signed({1'b0, r_lp_coef}) * zmy_c[c];
            p_dry_c[c] = $signed({1'b0, dry_gain}) * r_x[c];
            p_wet_c[c] = $signed({1'b0, r_wet_gain}) * tap_w[c];
            p_fb_c[c]  = $signed({1'b0, r_fb_gain}) * r_lp[c];
            fb_c[c]    = rnd16(WD'(r_p_fb[c]));
        end
        dly_we[0] = i_cfg_we && (i_cfg_addr == REG_DELAY_LEFT);
        dly_we[1] = i_cfg_we && (i_cfg_addr == REG_DELAY_RIGHT);
        wr_c[0] = sat_sb(WD'(r_x[0]) + (r_cross ? fb_c[1] : fb_c[0]));
        wr_c[1] = sat_sb(WD'(r_x[1]) + (r_cross ? fb_c[0] : fb_c[1]));
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_MUL1;
                end
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_MUL3;
            S_MUL3: n_state = S_WR;
            S_WR: begin
                if (mem_we) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_left[r_wp]  <= wr_c[0];
            r_mem_right[r_wp] <= wr_c[1];
        end
        r_rd[0] <= r_mem_left[rd_addr[0]];
        r_rd[1] <= r_mem_right[rd_addr[1]];
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 2; c++) begin
            if (accept) begin
                r_x[c]  <= in_c[c];
                r_tv[c] <= r_wrapped || (rd_addr[c] < r_wp);
            end
            if (r_state == S_MUL1) begin
                r_tap[c]   <= tap_w[c];
                r_y[c]     <= y_c[c];
                r_p_hp[c]  <= p_hp_c[c];
                r_p_lp[c]  <= p_lp_c[c];
                r_p_dry[c] <= p_dry_c[c];
                r_p_wet[c] <= p_wet_c[c];
            end
            if (r_state == S_MUL2) begin
                r_mix[c] <= sat_sb(rnd16(WD'(r_p_dry[c]) + WD'(r_p_wet[c])));
            end
            if (r_state == S_MUL3) begin
                r_p_fb[c] <= p_fb_c[c];
            end
            if (mem_we) begin
                r_out[c] <= r_mix[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_wrapped   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int c = 0; c < 2; c++) begin
                r_hp[c] <= '0;
                r_lp[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_MUL2) begin
                for (int c = 0; c < 2; c++) begin
                    r_hp[c] <= sat_st(WD'(r_tap[c]) + rnd16(WD'(r_p_hp[c])));
                    r_lp[c] <= sat_st(WD'(r_y[c]) + rnd16(WD'(r_p_lp[c])));
                end
            end
            if (mem_we) begin
                r_out_valid <= 1'b1;
                if (r_wp == WP_LAST) begin
                    r_wp      <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_wp <= r_wp + 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_rem[0] <= RST_DELAY_REM;
            r_delay_rem[1] <= RST_DELAY_REM;
            r_quot[0]      <= '0;
            r_quot[1]      <= '0;
            r_red_cnt      <= '0;
            r_fb_gain      <= RST_FEEDBACK;
            r_wet_gain     <= RST_WET;
            r_hp_coef      <= RST_HIGHPASS;
            r_lp_coef      <= RST_LOWPASS;
            r_cross        <= 1'b0;
        end else begin
            for (int c = 0; c < 2; c++) begin
                if (dly_we[c]) begin
                    r_delay_rem[c] <= i_cfg_data;
                end else if (r_red_cnt == RED_SUB) begin
                    r_delay_rem[c] <= r_delay_rem[c] - qd_c[c][CFG_W-1:0];
                end
                if (r_red_cnt == RED_MUL) begin
                    r_quot[c] <= prod_c[c][CFG_W+RCP_SH-1:RCP_SH];
                end
            end
            if (dly_we[0] || dly_we[1]) begin
                r_red_cnt <= RED_MUL;
            end else if (r_red_cnt != '0) begin
                r_red_cnt <= r_red_cnt - 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_FEEDBACK_GAIN: r_fb_gain  <= i_cfg_data;
                    REG_WET_GAIN:      r_wet_gain <= i_cfg_data;
                    REG_HIGHPASS_COEF: r_hp_coef  <= i_cfg_data;
                    REG_LOWPASS_COEF:  r_lp_coef  <= i_cfg_data;
                    REG_CROSS_MODE:    r_cross    <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_MUL1))
        else $error("Accepted transfer did not start the filter sequence.");

    a_wp_moves_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp != $past(r_wp)) |-> $past(mem_we))
        else $error("Write pointer moved without a line write.");

    a_result_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_WR))
        else $error("Result appeared without a completed item.");

    a_wrapped_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_wrapped) |-> r_wrapped)
        else $error("Fill tracking lost its wrap flag.");

    a_no_accept_reducing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_red_cnt != '0) |-> !accept)
        else $error("Transfer accepted during delay reduction.");

endmodule
